### hw/rtl/aec_pkg.sv
// ============================================================================
// aec_pkg - alpha edge classifier package
// Shared widths, request codes, table entry and write command types.
// ============================================================================
`default_nettype none

package aec_pkg;

   // Table capacity and field widths
   localparam int MAX_EDGES = 1024;
   localparam int IDX_W     = $clog2(MAX_EDGES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int BR_W      = 11;
   localparam int EPOCH_W   = 4;

   // Request codes carried in req_type
   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   // Sweep sequencer states
   typedef enum logic {
      SW_IDLE = 1'b0,
      SW_RUN  = 1'b1
   } sweep_state_type;

   // One row of the largest-incident table, tagged with the tree epoch
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [IDX_W-1:0]   val;
   } lat_entry_type;

   // Write commands from the state keeper to the tables
   typedef struct packed {
      logic              a_we;
      logic [IDX_W-1:0]  a_addr;
      logic [BR_W-1:0]   a_data;
      logic              l_we;
      logic [IDX_W-1:0]  l_addr;
      lat_entry_type     l_data;
   } tbl_wr_type;

endpackage

`default_nettype wire

### hw/rtl/aec_ifs.sv
// ============================================================================
// aec_ifs - alpha edge classifier channel interfaces
// Valid/ready channels for requests and responses.
// ============================================================================
`default_nettype none

interface aec_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic signed [aec_pkg::BR_W-1:0]     bridge_edge;
   logic [aec_pkg::IDX_W-1:0]           edge_index;

   modport source (output valid, output req_type, output bridge_edge,
                   output edge_index, input ready);
   modport sink   (input valid, input req_type, input bridge_edge,
                   input edge_index, output ready);
endinterface

interface aec_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic                                is_alpha;
   logic [aec_pkg::IDX_W-1:0]           max_incident;
   logic signed [aec_pkg::BR_W-1:0]     bridge_max_incident;

   modport source (output valid, output status, output is_alpha,
                   output max_incident, output bridge_max_incident, input ready);
   modport sink   (input valid, input status, input is_alpha,
                   input max_incident, input bridge_max_incident, output ready);
endinterface

`default_nettype wire

### hw/rtl/alpha_edge_classifier_unit.sv
// ============================================================================
// alpha_edge_classifier_unit - alpha edge classifier top level
// Loads tree edges in index order and answers alpha edge queries.
// ============================================================================
//
//   channel   direction  transfers                       result
//   req_bus   in         clear / load / query            none for clear
//   rsp_bus   out        status and query answer         one per load or query
//
// One item enters per cycle while req_bus.ready is high; each result passes the
// read stage, then the result stage: one dependent table read in each (bridge row,
// then its incident row). After reset and every sixteenth clear, the incident
// table is swept one row a cycle while the read stage is empty, req_bus.ready low.
// A stalled response holds; one further item waits in the read stage.
//
`default_nettype none

module alpha_edge_classifier_unit (
   input  wire logic     clock,
   input  wire logic     reset,
   aec_req_if.sink       req_bus,
   aec_rsp_if.source     rsp_bus
);

   logic                            adv_out, s1_free, accept, is_load, is_query, move;
   logic                            sweeping;
   logic [aec_pkg::CNT_W-1:0]       edge_count;
   logic signed [aec_pkg::BR_W-1:0] root_latest;
   logic [aec_pkg::EPOCH_W-1:0]     epoch;
   aec_pkg::tbl_wr_type             tbl_wr;
   logic [aec_pkg::BR_W-1:0]        bridge_rd;
   aec_pkg::lat_entry_type          lat1_rd, lat2_rd;

   // Read stage
   logic                            s1_v_ff, s1_v_in;
   logic                            s1_query_ff, s1_status_ff, s1_status_in;
   logic [aec_pkg::IDX_W-1:0]       s1_k_ff;
   logic [aec_pkg::CNT_W-1:0]       s1_count_ff;
   logic signed [aec_pkg::BR_W-1:0] s1_root_ff;
   logic [aec_pkg::EPOCH_W-1:0]     s1_epoch_ff;

   // Result stage
   logic                            out_v_ff, out_v_in;
   logic                            out_query_ff, out_status_ff;
   logic [aec_pkg::IDX_W-1:0]       out_k_ff, out_mi_ff, mi_in;
   logic [aec_pkg::BR_W-1:0]        out_kb_ff;
   logic                            out_kb_neg_ff, out_kb_loaded_ff, kb_loaded_in;
   logic signed [aec_pkg::BR_W-1:0] out_root_ff;
   logic [aec_pkg::EPOCH_W-1:0]     out_epoch_ff;

   logic signed [aec_pkg::BR_W-1:0] bm;
   logic                            ok;

   // Handshake and advance
   assign adv_out       = !out_v_ff || rsp_bus.ready;
   assign s1_free       = !s1_v_ff || adv_out;
   assign req_bus.ready = s1_free && !sweeping;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_load       = req_bus.req_type == aec_pkg::REQ_LOAD;
   assign is_query      = req_bus.req_type == aec_pkg::REQ_QUERY;
   assign move          = s1_v_ff && adv_out;

   aec_state u_state (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_bus.req_type),
      .bridge_edge (req_bus.bridge_edge),
      .pipe_busy   (s1_v_ff),
      .sweeping    (sweeping),
      .edge_count  (edge_count),
      .root_latest (root_latest),
      .epoch       (epoch),
      .tbl_wr      (tbl_wr)
   );

   aec_tables u_tables (
      .clock     (clock),
      .wr        (tbl_wr),
      .rd1_en    (accept),
      .rd1_addr  (req_bus.edge_index),
      .rd2_en    (move),
      .rd2_addr  (bridge_rd[aec_pkg::IDX_W-1:0]),
      .bridge_rd (bridge_rd),
      .lat1_rd   (lat1_rd),
      .lat2_rd   (lat2_rd)
   );

   // Read stage: capture the transfer and a snapshot of the tree state
   always_comb begin
      s1_v_in = s1_v_ff;
      if (s1_free) begin
         s1_v_in = accept && (is_load || is_query);
      end
      if (is_load) begin
         s1_status_in = edge_count >= aec_pkg::CNT_W'(aec_pkg::MAX_EDGES);
      end else begin
         s1_status_in = {1'b0, req_bus.edge_index} >= edge_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_query_ff  <= is_query;
         s1_status_ff <= s1_status_in;
         s1_k_ff      <= req_bus.edge_index;
         s1_count_ff  <= edge_count;
         s1_root_ff   <= root_latest;
         s1_epoch_ff  <= epoch;
      end
   end

   // Resolve the edge's own entry; a row from another epoch means nothing raised
   always_comb begin
      mi_in = (lat1_rd.tag == s1_epoch_ff) ? lat1_rd.val : s1_k_ff;
      kb_loaded_in = !bridge_rd[aec_pkg::BR_W-1]
                     && (bridge_rd < aec_pkg::BR_W'(s1_count_ff));
      out_v_in = out_v_ff;
      if (adv_out) begin
         out_v_in = s1_v_ff;
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_query_ff     <= s1_query_ff;
         out_status_ff    <= s1_status_ff;
         out_k_ff         <= s1_k_ff;
         out_mi_ff        <= mi_in;
         out_kb_ff        <= bridge_rd;
         out_kb_neg_ff    <= bridge_rd[aec_pkg::BR_W-1];
         out_kb_loaded_ff <= kb_loaded_in;
         out_root_ff      <= s1_root_ff;
         out_epoch_ff     <= s1_epoch_ff;
      end
   end

   // Bridge side: root register, raised row, or the bridge's own index
   always_comb begin
      if (out_kb_neg_ff) begin
         bm = out_root_ff;
      end else if (out_kb_loaded_ff && (lat2_rd.tag == out_epoch_ff)) begin
         bm = $signed({1'b0, lat2_rd.val});
      end else begin
         bm = $signed(out_kb_ff);
      end
   end

   assign ok                          = out_query_ff && !out_status_ff;
   assign rsp_bus.valid               = out_v_ff;
   assign rsp_bus.status              = out_status_ff;
   assign rsp_bus.is_alpha            = ok && (out_k_ff < out_mi_ff)
                                        && ($signed({1'b0, out_k_ff}) < bm);
   assign rsp_bus.max_incident        = ok ? out_mi_ff : '0;
   assign rsp_bus.bridge_max_incident = ok ? bm : '0;

endmodule

`default_nettype wire

### hw/rtl/aec_state.sv
// ============================================================================
// aec_state - tree state keeper
// Holds edge count, root register and epoch; issues table writes for loads
// and runs the table sweep after reset and on epoch wrap.
// ============================================================================
`default_nettype none

module aec_state (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [1:0]                      req_type,
   input  wire logic signed [aec_pkg::BR_W-1:0] bridge_edge,
   input  wire logic                            pipe_busy,
   output logic                                 sweeping,
   output logic [aec_pkg::CNT_W-1:0]            edge_count,
   output logic signed [aec_pkg::BR_W-1:0]      root_latest,
   output logic [aec_pkg::EPOCH_W-1:0]          epoch,
   output aec_pkg::tbl_wr_type                  tbl_wr
);

   localparam logic [aec_pkg::IDX_W-1:0] LAST_IDX = aec_pkg::IDX_W'(aec_pkg::MAX_EDGES - 1);

   logic [aec_pkg::CNT_W-1:0]       count_ff, count_in;
   logic signed [aec_pkg::BR_W-1:0] root_ff, root_in;
   logic [aec_pkg::EPOCH_W-1:0]     epoch_ff, epoch_in;
   aec_pkg::sweep_state_type        state_ff, state_in;
   logic [aec_pkg::IDX_W-1:0]       sweep_idx_ff, sweep_idx_in;
   logic                            sweep_wr;
   logic                            is_clear, is_load, full, load_ok, raise;
   logic signed [aec_pkg::BR_W-1:0] idx_s;

   // Decode the transfer
   assign is_clear = accept && (req_type == aec_pkg::REQ_CLEAR);
   assign is_load  = accept && (req_type == aec_pkg::REQ_LOAD);
   assign full     = count_ff >= aec_pkg::CNT_W'(aec_pkg::MAX_EDGES);
   assign load_ok  = is_load && !full;
   assign raise    = load_ok && !bridge_edge[aec_pkg::BR_W-1]
                     && ($unsigned(bridge_edge) < aec_pkg::BR_W'(count_ff));
   assign idx_s    = $signed(aec_pkg::BR_W'(count_ff));

   // Count, root register and epoch
   always_comb begin
      count_in = count_ff;
      root_in  = root_ff;
      epoch_in = epoch_ff;
      if (is_clear) begin
         count_in = '0;
         root_in  = -aec_pkg::BR_W'(1);
         epoch_in = epoch_ff + aec_pkg::EPOCH_W'(1);
      end else if (load_ok) begin
         count_in = count_ff + aec_pkg::CNT_W'(1);
         if (bridge_edge[aec_pkg::BR_W-1] && (idx_s > root_ff)) begin
            root_in = idx_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         root_ff  <= -aec_pkg::BR_W'(1);
         epoch_ff <= '0;
      end else begin
         count_ff <= count_in;
         root_ff  <= root_in;
         epoch_ff <= epoch_in;
      end
   end

   // Sweep sequencer: rewrite every row with its own index once the pipe drains
   always_comb begin
      state_in     = state_ff;
      sweep_idx_in = sweep_idx_ff;
      sweep_wr     = 1'b0;
      case (state_ff)
         aec_pkg::SW_IDLE: begin
            if (is_clear && (epoch_ff == {aec_pkg::EPOCH_W{1'b1}})) begin
               state_in     = aec_pkg::SW_RUN;
               sweep_idx_in = '0;
            end
         end
         aec_pkg::SW_RUN: begin
            if (!pipe_busy) begin
               sweep_wr     = 1'b1;
               sweep_idx_in = sweep_idx_ff + aec_pkg::IDX_W'(1);
               if (sweep_idx_ff == LAST_IDX) begin
                  state_in = aec_pkg::SW_IDLE;
               end
            end
         end
         default: begin
            state_in = aec_pkg::SW_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aec_pkg::SW_RUN;
         sweep_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
      end
   end

   // Table write commands
   always_comb begin
      tbl_wr.a_we   = load_ok;
      tbl_wr.a_addr = count_ff[aec_pkg::IDX_W-1:0];
      tbl_wr.a_data = $unsigned(bridge_edge);
      tbl_wr.l_we   = raise || sweep_wr;
      if (sweep_wr) begin
         tbl_wr.l_addr      = sweep_idx_ff;
         tbl_wr.l_data.tag  = '0;
         tbl_wr.l_data.val  = sweep_idx_ff;
      end else begin
         tbl_wr.l_addr      = bridge_edge[aec_pkg::IDX_W-1:0];
         tbl_wr.l_data.tag  = epoch_ff;
         tbl_wr.l_data.val  = count_ff[aec_pkg::IDX_W-1:0];
      end
   end

   assign sweeping    = (state_ff == aec_pkg::SW_RUN);
   assign edge_count  = count_ff;
   assign root_latest = root_ff;
   assign epoch       = epoch_ff;

endmodule

`default_nettype wire

### hw/rtl/aec_tables.sv
// ============================================================================
// aec_tables - edge tables
// Bridge table (one write, one read) and largest-incident table
// (one write, two reads), all reads registered with enables.
// ============================================================================
`default_nettype none

module aec_tables (
   input  wire logic                        clock,
   input  wire aec_pkg::tbl_wr_type         wr,
   input  wire logic                        rd1_en,
   input  wire logic [aec_pkg::IDX_W-1:0]   rd1_addr,
   input  wire logic                        rd2_en,
   input  wire logic [aec_pkg::IDX_W-1:0]   rd2_addr,
   output logic [aec_pkg::BR_W-1:0]         bridge_rd,
   output aec_pkg::lat_entry_type           lat1_rd,
   output aec_pkg::lat_entry_type           lat2_rd
);

   logic [aec_pkg::BR_W-1:0]    bridge_mem [aec_pkg::MAX_EDGES];
   aec_pkg::lat_entry_type      latest_mem [aec_pkg::MAX_EDGES];
   logic [aec_pkg::BR_W-1:0]    bridge_rd_ff;
   aec_pkg::lat_entry_type      lat1_rd_ff, lat2_rd_ff;

   // Bridge table
   always_ff @(posedge clock) begin
      if (wr.a_we) begin
         bridge_mem[wr.a_addr] <= wr.a_data;
      end
      if (rd1_en) begin
         bridge_rd_ff <= bridge_mem[rd1_addr];
      end
   end

   // Largest-incident table
   always_ff @(posedge clock) begin
      if (wr.l_we) begin
         latest_mem[wr.l_addr] <= wr.l_data;
      end
      if (rd1_en) begin
         lat1_rd_ff <= latest_mem[rd1_addr];
      end
      if (rd2_en) begin
         lat2_rd_ff <= latest_mem[rd2_addr];
      end
   end

   assign bridge_rd = bridge_rd_ff;
   assign lat1_rd   = lat1_rd_ff;
   assign lat2_rd   = lat2_rd_ff;

endmodule

`default_nettype wire

### hw/rtl/aec_checker.sv
// ============================================================================
// aec_checker - alpha edge classifier port checker
// Watches the top level's channels over time; bound to the top level.
// ============================================================================
`default_nettype none

module aec_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic [1:0]                      req_type,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_status,
   input wire logic                            rsp_is_alpha,
   input wire logic [aec_pkg::IDX_W-1:0]       rsp_max_incident,
   input wire logic signed [aec_pkg::BR_W-1:0] rsp_bridge_max_incident
);

   // A response waits until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // A failed request carries no answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         !rsp_is_alpha && (rsp_max_incident == '0) && (rsp_bridge_max_incident == '0))
      else $error("error response carries answer fields");

   // An alpha edge has later incident edges on both sides
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_alpha |->
         !rsp_status && (rsp_max_incident != '0) && (rsp_bridge_max_incident > 0))
      else $error("alpha edge without larger incident indices");

   // A fresh response traces back through the read stage to a load or query transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && ((req_type == aec_pkg::REQ_LOAD)
                                          || (req_type == aec_pkg::REQ_QUERY)), 2))
      else $error("response without a matching request");

   // The table sweep holds off requests straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request taken during table sweep");

endmodule

bind alpha_edge_classifier_unit aec_checker u_aec_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_bus.valid),
   .req_ready               (req_bus.ready),
   .req_type                (req_bus.req_type),
   .rsp_valid               (rsp_bus.valid),
   .rsp_ready               (rsp_bus.ready),
   .rsp_status              (rsp_bus.status),
   .rsp_is_alpha            (rsp_bus.is_alpha),
   .rsp_max_incident        (rsp_bus.max_incident),
   .rsp_bridge_max_incident (rsp_bus.bridge_max_incident)
);

`default_nettype wire

### tb/sv/testbench.sv
// ============================================================================
// testbench - alpha edge classifier unit
// Builds random trees: each one is a clear, then loads of edges with random
// bridges, then queries for its edges. A small table model predicts every
// response. Request gaps and response stalls vary by phase over the run.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

   localparam int BR_W      = aec_pkg::BR_W;
   localparam int IDX_W     = aec_pkg::IDX_W;
   localparam int MAX_EDGES = aec_pkg::MAX_EDGES;

   localparam logic [1:0] REQ_UNUSED = 2'd3;   // spare request code, ignored
   localparam int RANDOM_ITEMS   = 820;
   localparam int SHOWN_FAILURES = 10;
   localparam int DRAIN_CYCLES   = 20;

   typedef enum int {
      MODE_STEADY,
      MODE_SENDER_IDLE,
      MODE_SINK_STALL,
      MODE_BOTH_IDLE
   } idle_mode_type;

   typedef struct {
      logic [1:0]             code;
      logic signed [BR_W-1:0] bridge;
      logic [IDX_W-1:0]       index;
      idle_mode_type          mode;
   } edge_request_type;

   typedef struct packed {
      logic                   status;
      logic                   is_alpha;
      logic [IDX_W-1:0]       max_incident;
      logic signed [BR_W-1:0] bridge_max;
   } edge_answer_type;

   logic clock;
   logic reset;

   aec_req_if req_bus ();
   aec_rsp_if rsp_bus ();

   alpha_edge_classifier_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Tree table model
   logic signed [BR_W-1:0] bridge_tbl [MAX_EDGES];
   logic [IDX_W-1:0]       reach_tbl  [MAX_EDGES];
   int                     root_reach;
   int                     edges_held;

   edge_request_type request_queue [$];
   edge_answer_type  answer_queue [$];
   edge_request_type req_on_bus;
   logic             req_moved;
   idle_mode_type    current_mode;
   idle_mode_type    fill_mode;

   int n_clears, n_loads, n_full, n_queries, n_unloaded, n_alpha, n_ignored;
   int n_checked, fail_count;

   // Clock
   always #4 clock = ~clock;

   // Work out the answer that one accepted request should give, if any
   function automatic void predict_answer(edge_request_type rq);
      edge_answer_type ans;
      int b, k, mi, kb, bm;
      ans = '0;
      b   = rq.bridge;
      k   = rq.index;
      case (rq.code)
         aec_pkg::REQ_CLEAR: begin
            edges_held = 0;
            root_reach = -1;
            n_clears++;
         end
         aec_pkg::REQ_LOAD: begin
            n_loads++;
            if (edges_held >= MAX_EDGES) begin
               ans.status = 1'b1;
               n_full++;
            end else begin
               bridge_tbl[edges_held] = rq.bridge;
               reach_tbl[edges_held]  = IDX_W'(edges_held);
               // raise the bridge, or the root; a bridge not yet loaded is left alone
               if (b < 0) begin
                  if (edges_held > root_reach) root_reach = edges_held;
               end else if (b < edges_held) begin
                  if (edges_held > int'(reach_tbl[b])) reach_tbl[b] = IDX_W'(edges_held);
               end
               edges_held++;
            end
            answer_queue = {answer_queue, ans};
         end
         aec_pkg::REQ_QUERY: begin
            n_queries++;
            if (k >= edges_held) begin
               ans.status = 1'b1;
               n_unloaded++;
            end else begin
               mi = reach_tbl[k];
               kb = bridge_tbl[k];
               if (kb < 0) bm = root_reach;
               else if (kb < edges_held) bm = reach_tbl[kb];
               else bm = kb;
               ans.is_alpha     = (k < mi) && (k < bm);
               ans.max_incident = IDX_W'(mi);
               ans.bridge_max   = BR_W'(bm);
               if (ans.is_alpha) n_alpha++;
            end
            answer_queue = {answer_queue, ans};
         end
         default: begin
            n_ignored++;
         end
      endcase
   endfunction

   function automatic bit sender_rests(idle_mode_type m);
      return (m == MODE_SENDER_IDLE && $urandom_range(99) < 56) ||
             (m == MODE_BOTH_IDLE && $urandom_range(99) < 12);
   endfunction

   function automatic bit sink_stalls(idle_mode_type m);
      return (m == MODE_SINK_STALL && $urandom_range(99) < 56) ||
             (m == MODE_BOTH_IDLE && $urandom_range(99) < 12);
   endfunction

   function automatic void add_item(logic [1:0] code, int bridge, int index);
      edge_request_type rq;
      rq.code   = code;
      rq.bridge = BR_W'(bridge);
      rq.index  = IDX_W'(index);
      rq.mode   = fill_mode;
      request_queue = {request_queue, rq};
   endfunction

   function automatic int junk_bridge();
      return $urandom_range(2047);
   endfunction

   function automatic int junk_index();
      return $urandom_range(1023);
   endfunction

   // Queue one tree: clear, loads with mostly sound bridges, then queries.
   // Returns the number of requests that the block acts on.
   function automatic int add_tree(int tree_len);
      int added, q_count, r, b, k;
      added = 1;
      add_item(aec_pkg::REQ_CLEAR, junk_bridge(), junk_index());
      for (int idx = 0; idx < tree_len; idx++) begin
         r = $urandom_range(99);
         if (idx == 0 || r < 8) b = -1;
         else if (r < 92) b = $urandom_range(idx - 1);
         else if (r < 96) b = -int'($urandom_range(1024, 2));
         else b = $urandom_range(1023, idx);
         add_item(aec_pkg::REQ_LOAD, b, junk_index());
         added++;
         // ask early now and then, sometimes one past the loaded edges
         if ($urandom_range(99) < 8) begin
            add_item(aec_pkg::REQ_QUERY, junk_bridge(), $urandom_range(idx + 1));
            added++;
         end
         if ($urandom_range(99) < 2) add_item(REQ_UNUSED, junk_bridge(), junk_index());
      end
      q_count = $urandom_range(2 * tree_len, 1);
      if (q_count > 60) q_count = 60;
      for (int q = 0; q < q_count; q++) begin
         if (tree_len < MAX_EDGES && $urandom_range(99) < 15)
            k = $urandom_range(1023, tree_len);
         else
            k = $urandom_range(tree_len - 1);
         add_item(aec_pkg::REQ_QUERY, junk_bridge(), k);
         added++;
      end
      return added;
   endfunction

   // Record each request transfer and predict its answer
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         current_mode = req_on_bus.mode;
         predict_answer(req_on_bus);
         req_moved = 1'b1;
      end
   end

   // Drive requests from the queue, holding each one until it transfers
   always @(negedge clock) begin : drive_requests
      edge_request_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_moved) begin
         req_moved = 1'b0;
         if (request_queue.size() != 0 && !sender_rests(request_queue[0].mode)) begin
            rq = request_queue.pop_front();
            req_on_bus              = rq;
            req_bus.valid          <= 1'b1;
            req_bus.req_type       <= rq.code;
            req_bus.bridge_edge    <= rq.bridge;
            req_bus.edge_index     <= rq.index;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Stall the response channel as the current phase asks
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !sink_stalls(current_mode);
      end
   end

   // Check each response transfer against the oldest predicted answer
   always @(posedge clock) begin : check_answers
      edge_answer_type want, got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status       = rsp_bus.status;
         got.is_alpha     = rsp_bus.is_alpha;
         got.max_incident = rsp_bus.max_incident;
         got.bridge_max   = rsp_bus.bridge_max_incident;
         if (answer_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_FAILURES)
               $display("%0t: unexpected response: status %0b alpha %0b max %0d bmax %0d",
                        $realtime, got.status, got.is_alpha, got.max_incident,
                        got.bridge_max);
         end else begin
            want = answer_queue.pop_front();
            n_checked++;
            if (got !== want) begin
               fail_count++;
               if (fail_count <= SHOWN_FAILURES) begin
                  $display("%0t: response %0d expected status %0b alpha %0b max %0d bmax %0d",
                           $realtime, n_checked, want.status, want.is_alpha,
                           want.max_incident, want.bridge_max);
                  $display("%0t: response %0d got      status %0b alpha %0b max %0d bmax %0d",
                           $realtime, n_checked, got.status, got.is_alpha,
                           got.max_incident, got.bridge_max);
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin : run_test
      int random_count, tree_len;
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = aec_pkg::REQ_CLEAR;
      req_bus.bridge_edge = '0;
      req_bus.edge_index  = '0;
      rsp_bus.ready       = 1'b0;
      req_moved           = 1'b0;
      current_mode        = MODE_STEADY;
      fill_mode           = MODE_STEADY;
      edges_held          = 0;
      root_reach          = -1;

      // Directed: empty table, root and odd bridges, spare code, clear
      add_item(aec_pkg::REQ_QUERY, junk_bridge(), 0);
      add_item(aec_pkg::REQ_LOAD, -1, junk_index());
      add_item(aec_pkg::REQ_LOAD, 0, junk_index());
      add_item(aec_pkg::REQ_LOAD, -1024, junk_index());   // negative but not -1: root
      add_item(aec_pkg::REQ_LOAD, 5, junk_index());       // bridge loaded later
      add_item(aec_pkg::REQ_LOAD, 1023, junk_index());    // bridge never loaded
      add_item(aec_pkg::REQ_LOAD, 5, junk_index());       // bridge is the edge itself
      add_item(aec_pkg::REQ_LOAD, 1, junk_index());
      add_item(REQ_UNUSED, junk_bridge(), junk_index());
      for (int k = 0; k <= 7; k++) add_item(aec_pkg::REQ_QUERY, junk_bridge(), k);
      add_item(aec_pkg::REQ_QUERY, junk_bridge(), 1023);
      add_item(aec_pkg::REQ_CLEAR, junk_bridge(), junk_index());
      add_item(aec_pkg::REQ_QUERY, junk_bridge(), 0);
      add_item(aec_pkg::REQ_LOAD, -1, junk_index());
      add_item(aec_pkg::REQ_QUERY, junk_bridge(), 0);
      add_item(aec_pkg::REQ_LOAD, -1, junk_index());
      add_item(aec_pkg::REQ_LOAD, 0, junk_index());
      add_item(aec_pkg::REQ_QUERY, junk_bridge(), 0);

      // Random trees, mostly small, moving through the idle phases
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         fill_mode = idle_mode_type'((random_count * 4 / RANDOM_ITEMS) % 4);
         tree_len  = ($urandom_range(9) == 0) ? $urandom_range(120, 41)
                                              : $urandom_range(40, 1);
         random_count += add_tree(tree_len);
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Drain: all requests out, all answers back, then a few idle cycles
      while (request_queue.size() != 0 || req_bus.valid || answer_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (answer_queue.size() != 0) begin
         fail_count += answer_queue.size();
         $display("%0d predicted answers never arrived", answer_queue.size());
      end

      $display("Sent %0d clears, %0d loads (%0d full), %0d queries (%0d unloaded, %0d alpha)",
               n_clears, n_loads, n_full, n_queries, n_unloaded, n_alpha);
      $display("Checked %0d responses over four idle phases, %0d spare codes, %0d failures",
               n_checked, n_ignored, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #400000;
      $display("run timed out with %0d requests and %0d answers outstanding",
               request_queue.size(), answer_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
